FILE: rtl/tccw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the text console cell writer.
// No dependencies; the front end, back end and core refer to this package by scoped names.
package tccw_pkg;

  parameter int ColumnsDef = 80;
  parameter int RowsDef    = 25;

  localparam logic [7:0] BlankChar       = 8'h20;
  localparam logic [7:0] TextAttrReset   = 8'h07;
  localparam logic [7:0] CursorAttrReset = 8'h70;
  localparam logic [7:0] CharBackspace   = 8'd8;
  localparam logic [7:0] CharLineFeed    = 8'd10;
  localparam logic [7:0] CharReturn      = 8'd13;

  // Command codes on the input port.
  typedef enum logic [2:0] {
    KIND_PUT_CHAR   = 3'd0,
    KIND_SET_CURSOR = 3'd1,
    KIND_FOREGROUND = 3'd2,
    KIND_BACKGROUND = 3'd3,
    KIND_CLEAR      = 3'd4,
    KIND_CURSOR_ON  = 3'd5,
    KIND_CURSOR_OFF = 3'd6,
    KIND_READ_CELL  = 3'd7
  } kind_e;

  // Classified operations passed from the front to the back.
  localparam int OpKindW = 4;
  typedef enum logic [OpKindW-1:0] {
    OP_PRINT   = 4'd0,
    OP_BS      = 4'd1,
    OP_CR      = 4'd2,
    OP_LF      = 4'd3,
    OP_SETCUR  = 4'd4,
    OP_FG      = 4'd5,
    OP_BG      = 4'd6,
    OP_CLEAR   = 4'd7,
    OP_CURON   = 4'd8,
    OP_CUROFF  = 4'd9,
    OP_READ    = 4'd10
  } op_e;

  // ANSI colour index to VGA colour nibble.
  function automatic logic [3:0] vga_of_ansi(input logic [2:0] idx);
    logic [3:0] res;
    unique case (idx)
      3'd0:    res = 4'h0;
      3'd1:    res = 4'h4;
      3'd2:    res = 4'h2;
      3'd3:    res = 4'he;
      3'd4:    res = 4'h1;
      3'd5:    res = 4'h5;
      3'd6:    res = 4'h3;
      3'd7:    res = 4'h7;
      default: res = 4'h0;
    endcase
    return res;
  endfunction

endpackage

FILE: rtl/tccw_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tccw_ram #(
  parameter int Width = 8,
  parameter int Depth = 2000,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/tccw_fifo.sv
`timescale 1ns / 1ps
// Short queue of classified operations between front and back.
// No dependencies.
module tccw_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2,
  localparam int PtrW = $clog2(Depth),
  localparam int CntW = $clog2(Depth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);

  logic [Width-1:0] slot_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_d = CntW'(count_q + 1'b1);
    end else if (do_pop && !do_push) begin
      count_d = CntW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/tccw_front.sv
`timescale 1ns / 1ps
// Front end: takes input commands, saturates coordinates, classifies them.
// Depends on tccw_pkg; feeds tccw_fifo.
module tccw_front #(
  parameter int COLUMNS = tccw_pkg::ColumnsDef,
  parameter int ROWS    = tccw_pkg::RowsDef,
  localparam int ColW  = $clog2(COLUMNS),
  localparam int RowW  = $clog2(ROWS),
  localparam int CellW = $clog2(COLUMNS * ROWS),
  localparam int OpW   = tccw_pkg::OpKindW + 8 + ColW + RowW + CellW + 4 + 1
) (
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [2:0]      kind_i,
  input  logic [7:0]      char_code_i,
  input  logic [ColW-1:0] column_i,
  input  logic [RowW-1:0] row_i,
  input  logic [2:0]      colour_i,
  input  logic            home_cursor_i,
  input  logic            full_i,
  input  logic            busy_i,
  output logic            push_o,
  output logic [OpW-1:0]  op_o
);

  typedef struct packed {
    tccw_pkg::op_e   kind;
    logic [7:0]      ch;
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    logic [CellW-1:0] cell_idx;
    logic [3:0]      nib;
    logic            home;
  } op_t;

  op_t             op;
  logic [ColW-1:0] col_c;
  logic [RowW-1:0] row_c;

  assign in_stall_o = full_i || busy_i;
  assign push_o     = in_valid_i && !in_stall_o;

  // Saturate coordinates to the last column and row.
  assign col_c = (column_i > ColW'(COLUMNS - 1)) ? ColW'(COLUMNS - 1) : column_i;
  assign row_c = (row_i > RowW'(ROWS - 1)) ? RowW'(ROWS - 1) : row_i;

  always_comb begin
    op.ch       = char_code_i;
    op.col      = col_c;
    op.row      = row_c;
    op.cell_idx = CellW'(CellW'(row_c) * CellW'(COLUMNS) + CellW'(col_c));
    op.nib      = tccw_pkg::vga_of_ansi(colour_i);
    op.home     = home_cursor_i;
    unique case (tccw_pkg::kind_e'(kind_i))
      tccw_pkg::KIND_PUT_CHAR: begin
        priority if (char_code_i == tccw_pkg::CharBackspace) begin
          op.kind = tccw_pkg::OP_BS;
        end else if (char_code_i == tccw_pkg::CharReturn) begin
          op.kind = tccw_pkg::OP_CR;
        end else if (char_code_i == tccw_pkg::CharLineFeed) begin
          op.kind = tccw_pkg::OP_LF;
        end else begin
          op.kind = tccw_pkg::OP_PRINT;
        end
      end
      tccw_pkg::KIND_SET_CURSOR: op.kind = tccw_pkg::OP_SETCUR;
      tccw_pkg::KIND_FOREGROUND: op.kind = tccw_pkg::OP_FG;
      tccw_pkg::KIND_BACKGROUND: op.kind = tccw_pkg::OP_BG;
      tccw_pkg::KIND_CLEAR:      op.kind = tccw_pkg::OP_CLEAR;
      tccw_pkg::KIND_CURSOR_ON:  op.kind = tccw_pkg::OP_CURON;
      tccw_pkg::KIND_CURSOR_OFF: op.kind = tccw_pkg::OP_CUROFF;
      tccw_pkg::KIND_READ_CELL:  op.kind = tccw_pkg::OP_READ;
      default:                   op.kind = tccw_pkg::OP_READ;
    endcase
  end

  assign op_o = op;

endmodule

FILE: rtl/tccw_back.sv
`timescale 1ns / 1ps
// Back end: executes classified operations against the cell store.
// Depends on tccw_pkg and tccw_ram; takes operations from tccw_fifo.
module tccw_back #(
  parameter int COLUMNS = tccw_pkg::ColumnsDef,
  parameter int ROWS    = tccw_pkg::RowsDef,
  localparam int ColW  = $clog2(COLUMNS),
  localparam int RowW  = $clog2(ROWS),
  localparam int Cells = COLUMNS * ROWS,
  localparam int CellW = $clog2(Cells),
  localparam int CntW  = $clog2(Cells + 1),
  localparam int OpW   = tccw_pkg::OpKindW + 8 + ColW + RowW + CellW + 4 + 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [7:0]      cursor_attr_i,
  input  logic            q_valid_i,
  input  logic [OpW-1:0]  q_op_i,
  output logic            q_pop_o,
  output logic            busy_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [ColW-1:0] cursor_column_o,
  output logic [RowW-1:0] cursor_row_o,
  output logic [7:0]      cell_char_o,
  output logic [7:0]      cell_attribute_o,
  output logic [7:0]      current_attribute_o
);

  typedef struct packed {
    tccw_pkg::op_e   kind;
    logic [7:0]      ch;
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    logic [CellW-1:0] cell_idx;
    logic [3:0]      nib;
    logic            home;
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SHOW = 5'b00010,
    S_COPY = 5'b00100,
    S_FILL = 5'b01000,
    S_READ = 5'b10000
  } state_e;

  op_t              op;
  state_e           state_q, state_d;
  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic             shown_q, shown_d;
  logic [7:0]       tattr_q, tattr_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic             init_q, init_d;
  logic             out_valid_q, out_valid_d;
  logic [ColW-1:0]  out_col_q;
  logic [RowW-1:0]  out_row_q;
  logic [7:0]       out_char_q, out_attr_q, out_cur_q;

  logic             slot_free, done;
  logic [CellW-1:0] cur_addr;
  logic             we_char, we_attr;
  logic [CellW-1:0] waddr, raddr;
  logic [7:0]       wchar, wattr, rd_char, rd_attr;

  assign op        = op_t'(q_op_i);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign cur_addr  = CellW'(CellW'(row_q) * CellW'(COLUMNS) + CellW'(col_q));
  assign q_pop_o   = (state_q == S_IDLE) && q_valid_i && slot_free;
  assign busy_o    = init_q;

  tccw_ram #(.Width(8), .Depth(Cells)) u_char_ram (
    .clk_i   (clk_i),
    .we_i    (we_char),
    .waddr_i (waddr),
    .wdata_i (wchar),
    .raddr_i (raddr),
    .rdata_o (rd_char)
  );

  tccw_ram #(.Width(8), .Depth(Cells)) u_attr_ram (
    .clk_i   (clk_i),
    .we_i    (we_attr),
    .waddr_i (waddr),
    .wdata_i (wattr),
    .raddr_i (raddr),
    .rdata_o (rd_attr)
  );

  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    row_d   = row_q;
    shown_d = shown_q;
    tattr_d = tattr_q;
    idx_d   = idx_q;
    init_d  = init_q;
    done    = 1'b0;
    we_char = 1'b0;
    we_attr = 1'b0;
    waddr   = cur_addr;
    wchar   = op.ch;
    wattr   = tattr_q;
    raddr   = idx_q[CellW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (q_pop_o) begin
          unique case (op.kind)
            tccw_pkg::OP_PRINT: begin
              // Drop the cursor mark and write the character in one go.
              we_attr = 1'b1;
              we_char = 1'b1;
              col_d   = '0;
              if (col_q == ColW'(COLUMNS - 1) && row_q == RowW'(ROWS - 1)) begin
                idx_d   = CntW'(COLUMNS);
                state_d = S_COPY;
              end else if (col_q == ColW'(COLUMNS - 1)) begin
                row_d   = RowW'(row_q + 1'b1);
                state_d = S_SHOW;
              end else begin
                col_d   = ColW'(col_q + 1'b1);
                state_d = S_SHOW;
              end
            end
            tccw_pkg::OP_BS: begin
              if (col_q == '0 && row_q == '0) begin
                done = 1'b1;
              end else begin
                we_attr = 1'b1;
                state_d = S_SHOW;
                if (col_q == '0) begin
                  col_d = ColW'(COLUMNS - 1);
                  row_d = RowW'(row_q - 1'b1);
                end else begin
                  col_d = ColW'(col_q - 1'b1);
                end
              end
            end
            tccw_pkg::OP_CR: begin
              we_attr = 1'b1;
              col_d   = '0;
              state_d = S_SHOW;
            end
            tccw_pkg::OP_LF: begin
              we_attr = 1'b1;
              col_d   = '0;
              if (row_q == RowW'(ROWS - 1)) begin
                idx_d   = CntW'(COLUMNS);
                state_d = S_COPY;
              end else begin
                row_d   = RowW'(row_q + 1'b1);
                state_d = S_SHOW;
              end
            end
            tccw_pkg::OP_SETCUR: begin
              we_attr = 1'b1;
              col_d   = op.col;
              row_d   = op.row;
              state_d = S_SHOW;
            end
            tccw_pkg::OP_FG: begin
              tattr_d = {tattr_q[7:4], op.nib};
              done    = 1'b1;
            end
            tccw_pkg::OP_BG: begin
              tattr_d = {op.nib, tattr_q[3:0]};
              done    = 1'b1;
            end
            tccw_pkg::OP_CLEAR: begin
              if (op.home) begin
                col_d = '0;
                row_d = '0;
              end
              idx_d   = '0;
              state_d = S_FILL;
            end
            tccw_pkg::OP_CURON: begin
              shown_d = 1'b1;
              we_attr = 1'b1;
              wattr   = cursor_attr_i;
              done    = 1'b1;
            end
            tccw_pkg::OP_CUROFF: begin
              shown_d = 1'b0;
              we_attr = 1'b1;
              done    = 1'b1;
            end
            tccw_pkg::OP_READ: begin
              raddr   = op.cell_idx;
              state_d = S_READ;
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      S_SHOW: begin
        we_attr = shown_q;
        wattr   = cursor_attr_i;
        done    = 1'b1;
        state_d = S_IDLE;
      end
      S_COPY: begin
        // Read one row ahead, write the previous read one row up.
        if (idx_q != CntW'(COLUMNS)) begin
          we_char = 1'b1;
          we_attr = 1'b1;
          waddr   = CellW'(CntW'(idx_q - CntW'(COLUMNS + 1)));
          wchar   = rd_char;
          wattr   = rd_attr;
        end
        if (idx_q == CntW'(Cells)) begin
          idx_d   = CntW'(Cells - COLUMNS);
          state_d = S_FILL;
        end else begin
          idx_d = CntW'(idx_q + 1'b1);
        end
      end
      S_FILL: begin
        we_char = 1'b1;
        we_attr = 1'b1;
        waddr   = idx_q[CellW-1:0];
        wchar   = tccw_pkg::BlankChar;
        wattr   = (init_q && idx_q == '0) ? tccw_pkg::CursorAttrReset : tattr_q;
        if (idx_q == CntW'(Cells - 1)) begin
          init_d  = 1'b0;
          state_d = init_q ? S_IDLE : S_SHOW;
        end else begin
          idx_d = CntW'(idx_q + 1'b1);
        end
      end
      S_READ: begin
        done    = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (done) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FILL;
      col_q       <= '0;
      row_q       <= '0;
      shown_q     <= 1'b1;
      tattr_q     <= tccw_pkg::TextAttrReset;
      idx_q       <= '0;
      init_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      shown_q     <= shown_d;
      tattr_q     <= tattr_d;
      idx_q       <= idx_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_col_q  <= col_d;
      out_row_q  <= row_d;
      out_cur_q  <= tattr_d;
      out_char_q <= (state_q == S_READ) ? rd_char : 8'h00;
      out_attr_q <= (state_q == S_READ) ? rd_attr : 8'h00;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign cursor_column_o     = out_col_q;
  assign cursor_row_o        = out_row_q;
  assign cell_char_o         = out_char_q;
  assign cell_attribute_o    = out_attr_q;
  assign current_attribute_o = out_cur_q;

endmodule

FILE: rtl/text_console_cell_writer_core.sv
`timescale 1ns / 1ps
// Path: each command is queued, then the back end runs it; colour, cursor on/off and a backspace at cell 0
//   finish on issue, other put char and set cursor go on through SHOW, read through READ, scroll through
//   COPY, FILL and SHOW, clear through FILL and SHOW. The result register loads as each one finishes.
// Flow: the back end takes a new command only once idle, and each cell store has a single write port.
// Reset: asynchronous, active low; a clearing pass then fills
//   the store with blanks, the cursor mark at cell 0, with input stalled meanwhile.
module text_console_cell_writer_core #(
  parameter int COLUMNS = tccw_pkg::ColumnsDef,
  parameter int ROWS    = tccw_pkg::RowsDef,
  localparam int ColW  = $clog2(COLUMNS),
  localparam int RowW  = $clog2(ROWS),
  localparam int CellW = $clog2(COLUMNS * ROWS),
  localparam int OpW   = tccw_pkg::OpKindW + 8 + ColW + RowW + CellW + 4 + 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // Configuration write channel: cursor attribute.
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [7:0]      cfg_data_i,
  // Command channel.
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [2:0]      kind_i,
  input  logic [7:0]      char_code_i,
  input  logic [ColW-1:0] column_i,
  input  logic [RowW-1:0] row_i,
  input  logic [2:0]      colour_i,
  input  logic            home_cursor_i,
  // Result channel.
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [ColW-1:0] cursor_column_o,
  output logic [RowW-1:0] cursor_row_o,
  output logic [7:0]      cell_char_o,
  output logic [7:0]      cell_attribute_o,
  output logic [7:0]      current_attribute_o
);

  logic [7:0]     cursor_attr_q;
  logic           q_push, q_full, q_pop, q_valid, busy;
  logic [OpW-1:0] front_op, q_op;

  // The register is always writable; the user must write it only while the block is idle (not enforced).
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_attr_q <= tccw_pkg::CursorAttrReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cursor_attr_q <= cfg_data_i;
    end
  end

  // Front: saturate coordinates, classify control characters, map colours.
  tccw_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .char_code_i   (char_code_i),
    .column_i      (column_i),
    .row_i         (row_i),
    .colour_i      (colour_i),
    .home_cursor_i (home_cursor_i),
    .full_i        (q_full),
    .busy_i        (busy),
    .push_o        (q_push),
    .op_o          (front_op)
  );

  // Two-entry queue decouples command intake from cell store sweeps.
  tccw_fifo #(.Width(OpW), .Depth(2)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (front_op),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_op)
  );

  // Back: cursor state, text attribute, cell store and result register.
  tccw_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cursor_attr_i       (cursor_attr_q),
    .q_valid_i           (q_valid),
    .q_op_i              (q_op),
    .q_pop_o             (q_pop),
    .busy_o              (busy),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .cursor_column_o     (cursor_column_o),
    .cursor_row_o        (cursor_row_o),
    .cell_char_o         (cell_char_o),
    .cell_attribute_o    (cell_attribute_o),
    .current_attribute_o (current_attribute_o)
  );

  // Hold off commands for the whole clearing pass after reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy |-> in_stall_o)
    else $error("command accepted during clearing pass");

  // Pop only a filled queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_valid)
    else $error("pop of empty queue");

  // Reported cursor always lies on the screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cursor_column_o <= ColW'(COLUMNS - 1)) &&
                    (cursor_row_o <= RowW'(ROWS - 1)))
    else $error("cursor outside the screen");

  // A held result stays valid and keeps its cursor column and current attribute while stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(cursor_column_o) &&
                                   $stable(current_attribute_o))
    else $error("stalled result changed");

endmodule
